/* design/calendar_date_difference_and_add_assert.svh */
// Assertion macros for the calendar date block.
// Used by the cdda modules; expects clk and rst_n in the including scope.
`ifndef CALENDAR_DATE_DIFFERENCE_AND_ADD_ASSERT_SVH
`define CALENDAR_DATE_DIFFERENCE_AND_ADD_ASSERT_SVH
`ifndef SYNTHESIS
`define CDDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cdda assertion failed");
`define CDDA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cdda assertion failed");
`else
`define CDDA_ASSERT(lbl, prop)
`define CDDA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/cdda_pkg.sv */
// Shared types, constants and calendar helper functions for the date block.
// No dependencies.
package cdda_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int COUNT_W  = 16;
  localparam int DIFF_W   = 22;
  localparam int STATUS_W = 3;
  localparam int LEAP_W   = YEAR_W - 1;
  localparam int STEP_W   = DAY_W + 1;
  localparam int YLEN_W   = 9;

  localparam logic [YEAR_W-1:0]  TOP_YEAR        = 14'd9999;
  localparam logic [YLEN_W-1:0]  DAYS_COMMON     = 9'd365;
  localparam logic [YLEN_W-1:0]  DAYS_LEAP       = 9'd366;
  localparam logic [DAY_W-1:0]   FEB_COMMON_LAST = 5'd28;
  localparam logic [DAY_W-1:0]   DAY_LAST        = 5'd31;
  localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
  localparam logic [MONTH_W-1:0] MONTHS          = 4'd12;
  localparam logic [1:0]         LEAP_ROUND      = 2'd3;

  localparam logic [DAY_W-1:0] LEN_COMMON [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAY_W-1:0] LEN_LEAP [13] = '{
    5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_FIRST  = 3'd1,
    STATUS_BAD_SECOND = 3'd2,
    STATUS_ORDER      = 3'd3,
    STATUS_OVERFLOW   = 3'd4
  } cdda_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOY1,
    ST_DOY2,
    ST_LEAPS,
    ST_ADD_MONTH,
    ST_ADD_YEAR,
    ST_DONE
  } cdda_state_t;

  // Request as handed from the front end to the sequencer
  typedef struct packed {
    logic                 op_add;
    cdda_status_t         status;
    logic [DAY_W-1:0]     d1;
    logic [MONTH_W-1:0]   m1;
    logic [YEAR_W-1:0]    y1;
    logic [DAY_W-1:0]     d2;
    logic [MONTH_W-1:0]   m2;
    logic [YEAR_W-1:0]    y2;
    logic [DIFF_W-1:0]    year_days;
    logic [LEAP_W-1:0]    leap_days;
  } cdda_job_t;

  typedef struct packed {
    cdda_status_t         status;
    logic [DIFF_W-1:0]    diff;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } cdda_res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } cdda_seq_stat_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    if (m <= MONTHS) begin
      len = leap ? LEN_LEAP[m] : LEN_COMMON[m];
    end
    return len;
  endfunction

  function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                   input logic [MONTH_W-1:0] m,
                                   input logic [YEAR_W-1:0] y);
    logic ok;
    ok = (d != '0) && (m != '0) && (m <= MONTHS) && (y <= TOP_YEAR);
    if ((m == MONTH_FEB) && (d > FEB_COMMON_LAST) && !is_leap(y)) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

/* design/cdda_alu.sv */
// Shared add/subtract unit used by every step of the date sequencer.
// Depends on cdda_pkg for the default width.
module cdda_alu #(
  parameter int W = cdda_pkg::DIFF_W + 1
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         borrow
);

  logic [W:0] total;

  assign total  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
  assign sum    = total[W-1:0];
  // a < b on subtract
  assign borrow = sub & ~total[W];

endmodule

/* design/cdda_seq.sv */
// Sequencer and working registers for date difference and day addition.
// Depends on cdda_pkg, cdda_alu and the assertion macro header.
`include "calendar_date_difference_and_add_assert.svh"

module cdda_seq #(
  parameter int COUNT_BITS = cdda_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  cdda_pkg::cdda_job_t       job,
  input  logic [COUNT_BITS-1:0]     count,
  input  logic                      res_take,
  output cdda_pkg::cdda_seq_stat_t  stat,
  output cdda_pkg::cdda_res_t       res
);
  import cdda_pkg::*;

  localparam int ALU_W = ((COUNT_BITS > DIFF_W) ? COUNT_BITS : DIFF_W) + 1;

  cdda_state_t          state_r, state_nxt;
  logic [ALU_W-1:0]     work_r, work_nxt;
  logic [DAY_W-1:0]     d_r, d_nxt;
  logic [MONTH_W-1:0]   m_r, m_nxt;
  logic [YEAR_W-1:0]    y_r, y_nxt;
  logic [MONTH_W-1:0]   idx_r, idx_nxt;
  cdda_job_t            job_r, job_nxt;
  cdda_status_t         status_r, status_nxt;

  logic [ALU_W-1:0]     alu_b, alu_sum;
  logic                 alu_sub, alu_borrow;

  logic [DAY_W-1:0]     ml1, ml2, cur_len;
  logic [STEP_W-1:0]    step;
  logic [YLEN_W-1:0]    year_len;
  logic                 more1, more2, work_zero, last_month, y_over;
  logic [YEAR_W-1:0]    y_inc;

  cdda_alu #(.W(ALU_W)) u_alu (
    .a      (work_r),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  assign ml1        = month_len(idx_r, is_leap(job_r.y1));
  assign ml2        = month_len(idx_r, is_leap(job_r.y2));
  assign cur_len    = month_len(m_r, is_leap(y_r));
  // days to reach the first of the next month; a day past the month end steps by one
  assign step       = ((d_r < cur_len) ? {1'b0, cur_len - d_r} : '0) + STEP_W'(1);
  assign year_len   = is_leap(y_r) ? DAYS_LEAP : DAYS_COMMON;
  assign more1      = (idx_r < job_r.m1);
  assign more2      = (idx_r < job_r.m2);
  assign work_zero  = (work_r == '0);
  assign last_month = (m_r == MONTHS);
  assign y_inc      = y_r + YEAR_W'(1);
  assign y_over     = (y_inc > TOP_YEAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (job.status != STATUS_OK) begin
            state_nxt = ST_DONE;
          end else if (job.op_add) begin
            state_nxt = ST_ADD_MONTH;
          end else begin
            state_nxt = ST_DOY1;
          end
        end
      end
      ST_DOY1: begin
        if (!more1) begin
          state_nxt = ST_DOY2;
        end
      end
      ST_DOY2: begin
        if (!more2) begin
          state_nxt = ST_LEAPS;
        end
      end
      ST_LEAPS: state_nxt = ST_DONE;
      ST_ADD_MONTH: begin
        if (work_zero || alu_borrow) begin
          state_nxt = ST_DONE;
        end else if (last_month) begin
          state_nxt = y_over ? ST_DONE : ST_ADD_YEAR;
        end
      end
      ST_ADD_YEAR: begin
        if (alu_borrow) begin
          state_nxt = ST_ADD_MONTH;
        end else if (y_over) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared unit operand select
  always_comb begin
    alu_sub = 1'b0;
    alu_b   = '0;
    unique case (state_r)
      ST_DOY1: begin
        if (more1) begin
          alu_b = ALU_W'(ml1);
        end else begin
          alu_sub = 1'b1;
          alu_b   = ALU_W'(job_r.d2);
        end
      end
      ST_DOY2: begin
        if (more2) begin
          alu_sub = 1'b1;
          alu_b   = ALU_W'(ml2);
        end else begin
          alu_b = ALU_W'(job_r.year_days);
        end
      end
      ST_LEAPS: alu_b = ALU_W'(job_r.leap_days);
      ST_ADD_MONTH: begin
        alu_sub = 1'b1;
        alu_b   = ALU_W'(step);
      end
      ST_ADD_YEAR: begin
        alu_sub = 1'b1;
        alu_b   = ALU_W'(year_len);
      end
      default: begin
        alu_sub = 1'b0;
        alu_b   = '0;
      end
    endcase
  end

  // working registers
  always_comb begin
    work_nxt   = work_r;
    d_nxt      = d_r;
    m_nxt      = m_r;
    y_nxt      = y_r;
    idx_nxt    = idx_r;
    job_nxt    = job_r;
    status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          job_nxt    = job;
          status_nxt = job.status;
          idx_nxt    = MONTH_W'(1);
          d_nxt      = job.d1;
          m_nxt      = job.m1;
          y_nxt      = job.y1;
          work_nxt   = job.op_add ? ALU_W'(count) : ALU_W'(job.d1);
        end
      end
      ST_DOY1: begin
        work_nxt = alu_sum;
        idx_nxt  = more1 ? (idx_r + MONTH_W'(1)) : MONTH_W'(1);
      end
      ST_DOY2: begin
        work_nxt = alu_sum;
        if (more2) begin
          idx_nxt = idx_r + MONTH_W'(1);
        end
      end
      ST_LEAPS: work_nxt = alu_sum;
      ST_ADD_MONTH: begin
        if (!work_zero) begin
          if (alu_borrow) begin
            // remainder fits in this month
            d_nxt = d_r + work_r[DAY_W-1:0];
          end else begin
            work_nxt = alu_sum;
            d_nxt    = DAY_W'(1);
            if (last_month) begin
              m_nxt = MONTH_W'(1);
              y_nxt = y_inc;
              if (y_over) begin
                status_nxt = STATUS_OVERFLOW;
              end
            end else begin
              m_nxt = m_r + MONTH_W'(1);
            end
          end
        end
      end
      ST_ADD_YEAR: begin
        if (!alu_borrow) begin
          work_nxt = alu_sum;
          y_nxt    = y_inc;
          if (y_over) begin
            status_nxt = STATUS_OVERFLOW;
          end
        end
      end
      default: begin
        work_nxt = work_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    d_r      <= d_nxt;
    m_r      <= m_nxt;
    y_r      <= y_nxt;
    idx_r    <= idx_nxt;
    job_r    <= job_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    res        = '0;
    res.status = status_r;
    if (status_r == STATUS_OVERFLOW) begin
      res.day   = DAY_LAST;
      res.month = MONTHS;
      res.year  = TOP_YEAR;
    end else if (status_r == STATUS_OK) begin
      if (job_r.op_add) begin
        res.day   = d_r;
        res.month = m_r;
        res.year  = y_r;
      end else begin
        // negative span (same-year overlong days) clamps to zero
        res.diff = work_r[ALU_W-1] ? '0 : work_r[DIFF_W-1:0];
      end
    end
  end

  assign stat.idle      = (state_r == ST_IDLE);
  assign stat.res_valid = (state_r == ST_DONE);

  `CDDA_ASSERT(a_start_idle, start |-> (state_r == ST_IDLE))
  `CDDA_ASSERT(a_add_month_range, ((state_r == ST_ADD_MONTH) || (state_r == ST_ADD_YEAR)) |-> ((m_r != '0) && (m_r <= MONTHS) && (y_r <= TOP_YEAR)))
  `CDDA_ASSERT(a_idx_range, ((state_r == ST_DOY1) || (state_r == ST_DOY2)) |-> (idx_r <= MONTHS))
  `CDDA_ASSERT_NEXT(a_done_hold, (state_r == ST_DONE) && !res_take, (state_r == ST_DONE) && $stable(work_r) && $stable(status_r))

endmodule

/* design/calendar_date_difference_and_add.sv */
// Calendar date difference / add-days block, one request at a time. A
// difference request walks both dates' month tables on one shared adder.
// An add request steps one month or one whole year per cycle on the same
// adder. Invalid dates and out-of-order pairs go straight from idle to the
// result state. in_ready is high only while the sequencer is idle; a
// finished word sits in the output register so the next request can be
// taken while it waits.
// Depends on cdda_pkg, cdda_seq, cdda_alu.
`include "calendar_date_difference_and_add_assert.svh"

module calendar_date_difference_and_add #(
  parameter int COUNT_BITS = cdda_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [cdda_pkg::DAY_W-1:0]     in_first_day,
  input  logic [cdda_pkg::MONTH_W-1:0]   in_first_month,
  input  logic [cdda_pkg::YEAR_W-1:0]    in_first_year,
  input  logic [cdda_pkg::DAY_W-1:0]     in_second_day,
  input  logic [cdda_pkg::MONTH_W-1:0]   in_second_month,
  input  logic [cdda_pkg::YEAR_W-1:0]    in_second_year,
  input  logic [cdda_pkg::COUNT_W-1:0]   in_day_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cdda_pkg::STATUS_W-1:0]  out_status,
  output logic [cdda_pkg::DIFF_W-1:0]    out_day_difference,
  output logic [cdda_pkg::DAY_W-1:0]     out_new_day,
  output logic [cdda_pkg::MONTH_W-1:0]   out_new_month,
  output logic [cdda_pkg::YEAR_W-1:0]    out_new_year
);
  import cdda_pkg::*;

  cdda_seq_stat_t         seq_stat;
  cdda_res_t              seq_res;
  cdda_job_t              job;
  logic                   start, res_take;
  logic [COUNT_BITS-1:0]  count;

  logic                   first_ok, second_ok, first_earlier;
  logic [YEAR_W-1:0]      year_span;
  logic [DIFF_W-1:0]      span_ext;
  logic [YEAR_W:0]        lb1_sum, lb2_sum;
  logic [LEAP_W-1:0]      lb1, lb2;

  logic                   out_valid_r, out_valid_nxt;
  cdda_res_t              out_res_r;

  assign first_ok      = date_ok(in_first_day, in_first_month, in_first_year);
  assign second_ok     = date_ok(in_second_day, in_second_month, in_second_year);
  assign first_earlier = (in_first_year < in_second_year) ||
                         ((in_first_year == in_second_year) &&
                          ((in_first_month < in_second_month) ||
                           ((in_first_month == in_second_month) &&
                            (in_first_day < in_second_day))));

  // whole-year span and leap years in [y2, y1)
  assign year_span = in_first_year - in_second_year;
  assign span_ext  = DIFF_W'(year_span);
  assign lb1_sum   = {1'b0, in_first_year} + (YEAR_W+1)'(LEAP_ROUND);
  assign lb2_sum   = {1'b0, in_second_year} + (YEAR_W+1)'(LEAP_ROUND);
  assign lb1       = lb1_sum[YEAR_W:2];
  assign lb2       = lb2_sum[YEAR_W:2];

  always_comb begin
    job.op_add    = in_operation;
    job.d1        = in_first_day;
    job.m1        = in_first_month;
    job.y1        = in_first_year;
    job.d2        = in_second_day;
    job.m2        = in_second_month;
    job.y2        = in_second_year;
    job.year_days = DIFF_W'(span_ext * DIFF_W'(DAYS_COMMON));
    job.leap_days = lb1 - lb2;
    priority if (!first_ok) begin
      job.status = STATUS_BAD_FIRST;
    end else if (in_operation) begin
      job.status = STATUS_OK;
    end else if (!second_ok) begin
      job.status = STATUS_BAD_SECOND;
    end else if (first_earlier) begin
      job.status = STATUS_ORDER;
    end else begin
      job.status = STATUS_OK;
    end
  end

  assign count    = COUNT_BITS'(in_day_count);
  assign in_ready = seq_stat.idle;
  assign start    = in_valid & seq_stat.idle;
  assign res_take = seq_stat.res_valid & (~out_valid_r | out_ready);

  cdda_seq #(.COUNT_BITS(COUNT_BITS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .job      (job),
    .count    (count),
    .res_take (res_take),
    .stat     (seq_stat),
    .res      (seq_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_day_difference = out_res_r.diff;
  assign out_new_day        = out_res_r.day;
  assign out_new_month      = out_res_r.month;
  assign out_new_year       = out_res_r.year;

  `CDDA_ASSERT(a_take_slot_free, res_take |-> (!out_valid_r || out_ready))
  `CDDA_ASSERT(a_busy_not_ready, (!seq_stat.idle) |-> !in_ready)
  `CDDA_ASSERT_NEXT(a_take_valid, res_take, out_valid_r && !seq_stat.res_valid)

endmodule

/* tb/calendar_date_difference_and_add_tb.sv */
// Testbench for calendar_date_difference_and_add: directed and random requests
// checked word by word against a built-in calendar predictor. Needs cdda_pkg.
`timescale 1ns / 100ps

module calendar_date_difference_and_add_tb;
  import cdda_pkg::*;

  localparam bit          OP_DIFFERENCE = 1'b0;
  localparam bit          OP_ADD        = 1'b1;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned DRAIN_CYCLES  = 250;
  localparam int unsigned STALL_CYCLES  = 600;

  typedef struct {
    bit                 op;
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
    logic [COUNT_W-1:0] day_count;
  } calendar_req_t;

  typedef struct packed {
    cdda_status_t       status;
    logic [DIFF_W-1:0]  day_difference;
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
  } calendar_answer_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_operation;
  logic [DAY_W-1:0]    in_first_day;
  logic [MONTH_W-1:0]  in_first_month;
  logic [YEAR_W-1:0]   in_first_year;
  logic [DAY_W-1:0]    in_second_day;
  logic [MONTH_W-1:0]  in_second_month;
  logic [YEAR_W-1:0]   in_second_year;
  logic [COUNT_W-1:0]  in_day_count;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [DIFF_W-1:0]   out_day_difference;
  logic [DAY_W-1:0]    out_new_day;
  logic [MONTH_W-1:0]  out_new_month;
  logic [YEAR_W-1:0]   out_new_year;

  calendar_answer_t calendar_answers_q[$];
  int unsigned      failures;
  int unsigned      cycle_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      stall_left;

  calendar_date_difference_and_add DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_first_day       (in_first_day),
    .in_first_month     (in_first_month),
    .in_first_year      (in_first_year),
    .in_second_day      (in_second_day),
    .in_second_month    (in_second_month),
    .in_second_year     (in_second_year),
    .in_day_count       (in_day_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_day_difference (out_day_difference),
    .out_new_day        (out_new_day),
    .out_new_month      (out_new_month),
    .out_new_year       (out_new_year)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit leap_year(int unsigned y);
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2:          return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      0:          return 0;
      default:    return (m > 12) ? 0 : 31;
    endcase
  endfunction

  function automatic int unsigned year_length(int unsigned y);
    return leap_year(y) ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
    if (d == 0 || d > DAY_LAST || m == 0 || m > MONTHS || y > TOP_YEAR) return 1'b0;
    // Feb 29..31 only passes in a leap year; other overlong days are let through
    if (m == MONTH_FEB && d > FEB_COMMON_LAST && !leap_year(y)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int day_of_year(int unsigned d, int unsigned m, int unsigned y);
    int t;
    t = d;
    for (int unsigned i = 1; i < m; i++) t += days_in_month(i, y);
    return t;
  endfunction

  function automatic bit date_earlier(int unsigned d1, int unsigned m1, int unsigned y1,
                                      int unsigned d2, int unsigned m2, int unsigned y2);
    return (y1 < y2) || (y1 == y2 && m1 < m2) || (y1 == y2 && m1 == m2 && d1 < d2);
  endfunction

  function automatic calendar_answer_t predict_calendar(calendar_req_t r);
    calendar_answer_t a;
    int               span;
    int unsigned      d, m, y, n, len, step;
    bit               over;
    a = '0;
    a.status = STATUS_OK;
    d = r.first_day;
    m = r.first_month;
    y = r.first_year;
    n = r.day_count;
    over = 1'b0;
    if (!date_valid(d, m, y)) begin
      a.status = STATUS_BAD_FIRST;
    end else if (r.op == OP_DIFFERENCE) begin
      if (!date_valid(r.second_day, r.second_month, r.second_year)) begin
        a.status = STATUS_BAD_SECOND;
      end else if (date_earlier(d, m, y, r.second_day, r.second_month, r.second_year)) begin
        a.status = STATUS_ORDER;
      end else begin
        span = day_of_year(d, m, y) - day_of_year(r.second_day, r.second_month, r.second_year)
             + 365 * (int'(y) - int'(r.second_year))
             + int'((y + 3) / 4) - int'((r.second_year + 3) / 4);
        // overlong days in the earlier month can make the span negative
        a.day_difference = (span < 0) ? '0 : span;
      end
    end else begin
      while (n > 0) begin
        len = days_in_month(m, y);
        if (d < len && n <= len - d) begin
          d += n;
          n = 0;
        end else begin
          step = ((d < len) ? len - d : 0) + 1;
          n -= step;
          d = 1;
          m++;
          if (m > MONTHS) begin
            m = 1;
            y++;
            if (y > TOP_YEAR) begin
              over = 1'b1;
              break;
            end
            // skip whole years; the leap flag tracks the current year
            while (n >= year_length(y)) begin
              n -= year_length(y);
              y++;
              if (y > TOP_YEAR) begin
                over = 1'b1;
                break;
              end
            end
            if (over) break;
          end
        end
      end
      if (over) begin
        a.status    = STATUS_OVERFLOW;
        a.new_day   = DAY_LAST;
        a.new_month = MONTHS;
        a.new_year  = TOP_YEAR;
      end else begin
        a.new_day   = d;
        a.new_month = m;
        a.new_year  = y;
      end
    end
    return a;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic calendar_req_t make_req(bit op, int unsigned d1, int unsigned m1,
                                             int unsigned y1, int unsigned d2,
                                             int unsigned m2, int unsigned y2,
                                             int unsigned count);
    calendar_req_t r;
    r.op           = op;
    r.first_day    = d1;
    r.first_month  = m1;
    r.first_year   = y1;
    r.second_day   = d2;
    r.second_month = m2;
    r.second_year  = y2;
    r.day_count    = count;
    return r;
  endfunction

  // entered right after a rising edge; returns at the edge that took the word
  task automatic send_request(input calendar_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_first_day    <= r.first_day;
    in_first_month  <= r.first_month;
    in_first_year   <= r.first_year;
    in_second_day   <= r.second_day;
    in_second_month <= r.second_month;
    in_second_year  <= r.second_year;
    in_day_count    <= r.day_count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calendar_answers_q.push_back(predict_calendar(r));
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (calendar_answers_q.size() != 0) @(posedge clk);
  endtask

  task automatic pick_date(input int year_hint, output logic [DAY_W-1:0] d,
                           output logic [MONTH_W-1:0] m, output logic [YEAR_W-1:0] y);
    int unsigned pick;
    pick = $urandom_range(9);
    if (year_hint >= 0)  y = year_hint;
    else if (pick == 0)  y = $urandom_range(3);
    else if (pick == 1)  y = $urandom_range(9999, 9996);
    else                 y = $urandom_range(9999);
    m = $urandom_range(12, 1);
    if ($urandom_range(3) == 0) d = $urandom_range(31, 27);
    else                        d = $urandom_range(31, 1);
    if (m == MONTH_FEB && d > FEB_COMMON_LAST && !leap_year(y)) d = $urandom_range(28, 26);
  endtask

  task automatic random_difference(output calendar_req_t r);
    int                 hint;
    logic [DAY_W-1:0]   td;
    logic [MONTH_W-1:0] tm;
    logic [YEAR_W-1:0]  ty;
    r = make_req(OP_DIFFERENCE, 0, 0, 0, 0, 0, 0, $urandom_range(65535));
    pick_date(-1, r.first_day, r.first_month, r.first_year);
    case ($urandom_range(3))
      0:       hint = r.first_year;
      1:       hint = (r.first_year > 20) ? r.first_year - $urandom_range(20) : 0;
      default: hint = -1;
    endcase
    pick_date(hint, r.second_day, r.second_month, r.second_year);
    if ($urandom_range(9) != 0 && date_earlier(r.first_day, r.first_month, r.first_year,
                                               r.second_day, r.second_month, r.second_year)) begin
      td = r.first_day;
      tm = r.first_month;
      ty = r.first_year;
      r.first_day    = r.second_day;
      r.first_month  = r.second_month;
      r.first_year   = r.second_year;
      r.second_day   = td;
      r.second_month = tm;
      r.second_year  = ty;
    end
  endtask

  task automatic random_add(output calendar_req_t r);
    r = make_req(OP_ADD, 0, 0, 0, $urandom_range(31), $urandom_range(15),
                 $urandom_range(16383), 0);
    pick_date(-1, r.first_day, r.first_month, r.first_year);
    case ($urandom_range(3))
      0:       r.day_count = $urandom_range(400);
      1:       r.day_count = $urandom_range(5000);
      default: r.day_count = $urandom_range(65535);
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    calendar_req_t reqs[$];
    reqs.push_back(make_req(OP_DIFFERENCE, 31, 12, 9999, 1, 1, 0, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 15, 6, 2000, 15, 6, 2000, 65535));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 3, 2024, 31, 2, 2024, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 5, 2023, 31, 4, 2023, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 0, 5, 2023, 1, 1, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 0, 2023, 1, 1, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 15, 2023, 1, 1, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 1, 16383, 1, 1, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 29, 2, 2023, 1, 1, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 1, 2023, 30, 2, 2021, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 1, 2023, 1, 13, 2021, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 1, 2000, 1, 1, 2001, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 1, 5, 2000, 1, 6, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 4, 5, 2000, 5, 5, 2000, 0));
    reqs.push_back(make_req(OP_DIFFERENCE, 29, 2, 2024, 28, 2, 2023, 0));
    reqs.push_back(make_req(OP_ADD, 10, 10, 2010, 0, 0, 0, 0));
    reqs.push_back(make_req(OP_ADD, 1, 1, 0, 0, 0, 0, 65535));
    reqs.push_back(make_req(OP_ADD, 31, 12, 9999, 0, 0, 0, 1));
    reqs.push_back(make_req(OP_ADD, 31, 12, 9999, 0, 0, 0, 0));
    reqs.push_back(make_req(OP_ADD, 28, 2, 2023, 0, 0, 0, 1));
    reqs.push_back(make_req(OP_ADD, 28, 2, 2024, 0, 0, 0, 1));
    reqs.push_back(make_req(OP_ADD, 31, 4, 2021, 0, 0, 0, 1));
    reqs.push_back(make_req(OP_ADD, 0, 1, 2000, 0, 0, 0, 100));
    reqs.push_back(make_req(OP_ADD, 1, 1, 9900, 0, 0, 0, 65535));
    reqs.push_back(make_req(OP_ADD, 31, 12, 1999, 0, 0, 16383, 366));
    foreach (reqs[i]) send_request(reqs[i]);
  endtask

  task automatic test_random(input int unsigned count);
    calendar_req_t r;
    repeat (count) begin
      case ($urandom_range(19))
        0, 1: begin
          r = make_req($urandom_range(1), $urandom_range(31), $urandom_range(15),
                       $urandom_range(16383), $urandom_range(31), $urandom_range(15),
                       $urandom_range(16383), $urandom_range(65535));
        end
        2, 3, 4, 5, 6, 7, 8, 9, 10: random_difference(r);
        default:                    random_add(r);
      endcase
      send_request(r);
    end
  endtask

  // output held off long enough for the block to fill and drop in_ready
  task automatic test_receiver_stall();
    calendar_req_t r;
    int unsigned   saved_idle;
    wait_for_answers();
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    stall_left = STALL_CYCLES;
    repeat (20) begin
      if ($urandom_range(1) == 0) begin
        random_difference(r);
      end else begin
        random_add(r);
        r.day_count = $urandom_range(60);
      end
      send_request(r);
    end
    // sender pauses until every outstanding word is back
    wait_for_answers();
    send_idle_pct = saved_idle;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      failures++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : answer_check
    calendar_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (calendar_answers_q.size() == 0) begin
        failures++;
        $error("result word with no request outstanding");
      end else begin
        want = calendar_answers_q.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("day_difference", want.day_difference, out_day_difference);
        compare_field("new_day", want.new_day, out_new_day);
        compare_field("new_month", want.new_month, out_new_month);
        compare_field("new_year", want.new_year, out_new_year);
      end
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    failures        = 0;
    cycle_count     = 0;
    stall_left      = 0;
    send_idle_pct   = 37;
    recv_idle_pct   = 45;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= OP_DIFFERENCE;
    in_first_day    <= '0;
    in_first_month  <= '0;
    in_first_year   <= '0;
    in_second_day   <= '0;
    in_second_month <= '0;
    in_second_year  <= '0;
    in_day_count    <= '0;
    out_ready       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(390);
    test_receiver_stall();
    send_idle_pct = 45;
    recv_idle_pct = 37;
    test_random(390);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(390);

    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/cdda_pkg.sv
design/cdda_alu.sv
design/cdda_seq.sv
design/calendar_date_difference_and_add.sv
tb/calendar_date_difference_and_add_tb.sv
